// ----- hdl/mesh_packet_route_filter_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the mesh packet route filter
// Concurrent checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MESH_PACKET_ROUTE_FILTER_TOP_DEFINES_SVH
`define MESH_PACKET_ROUTE_FILTER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MPRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MPRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mprf_pkg.sv -----
// ----------------------------------------------------------------------------
// mprf_pkg
// Shared constants, codes and types of the mesh packet route filter.
// ----------------------------------------------------------------------------
package mprf_pkg;

  // route table size and index width
  localparam int ROUTE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(ROUTE_ENTRIES);

  // frame parsing
  localparam int          POS_W      = 6;
  localparam logic [5:0]  MIN_LEN    = 6'd42;
  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] PRIMARY_PORT_RST = 16'd26969;
  localparam logic [15:0] SYNC_PORT_RST    = 16'd5000;

  // input operation codes (tuser)
  localparam logic [1:0] OP_FRAME  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // configuration register indexes
  localparam logic CFG_PRIMARY_PORT = 1'b0;
  localparam logic CFG_SYNC_PORT    = 1'b1;

  // result kinds and codes
  localparam logic       KIND_VERDICT = 1'b0;
  localparam logic       KIND_ROUTE   = 1'b1;
  localparam logic       VERDICT_PASS = 1'b0;
  localparam logic       VERDICT_DROP = 1'b1;
  localparam logic [1:0] CLS_NOT_MESH = 2'd0;
  localparam logic [1:0] CLS_ROUTED   = 2'd1;
  localparam logic [1:0] CLS_NO_ROUTE = 2'd2;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // stream widths
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_FIELDS_W = 1 + 2 + 32 + 2 + 4 * 64;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [1:0] {
    TBL_LOOKUP = 2'd0,
    TBL_INSERT = 2'd1,
    TBL_REMOVE = 2'd2
  } tbl_op_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] hop;
  } route_entry_t;

  typedef struct packed {
    logic        valid;
    tbl_op_t     op;
    logic [31:0] key;
    logic [31:0] hop;
  } tbl_req_t;

  typedef struct packed {
    logic        ready;
    logic        done;
    tbl_op_t     op;
    logic        found;
    logic [1:0]  status;
    logic [31:0] hop;
  } tbl_rsp_t;

endpackage

// ----- hdl/mprf_route_table.sv -----
// ----------------------------------------------------------------------------
// mprf_route_table
// Exact-match route table in one single-port-read memory, searched by a
// linear scan, one entry per cycle, with write-back at the end of the scan.
// ----------------------------------------------------------------------------
module mprf_route_table (
  input  logic               clk,
  input  logic               rst,
  input  mprf_pkg::tbl_req_t req,
  output mprf_pkg::tbl_rsp_t rsp
);

  typedef enum logic [2:0] {
    T_CLEAR = 3'b001,
    T_IDLE  = 3'b010,
    T_SCAN  = 3'b100
  } tbl_state_t;

  mprf_pkg::route_entry_t route_mem [mprf_pkg::ROUTE_ENTRIES];
  mprf_pkg::route_entry_t rd_data;

  tbl_state_t                  state, state_next;
  logic [mprf_pkg::IDX_W-1:0]  idx, idx_next;
  logic [mprf_pkg::IDX_W-1:0]  free_idx, free_idx_next;
  logic                        free_seen, free_seen_next;
  mprf_pkg::tbl_op_t           op_q, op_q_next;
  logic [31:0]                 key_q, key_q_next;
  logic [31:0]                 hop_q, hop_q_next;

  logic                        we;
  logic [mprf_pkg::IDX_W-1:0]  waddr;
  mprf_pkg::route_entry_t      wdata;
  logic [mprf_pkg::IDX_W-1:0]  raddr;
  logic                        hit;
  logic                        at_end;

  always_ff @(posedge clk) begin
    if (we) begin
      route_mem[waddr] <= wdata;
    end
    rd_data <= route_mem[raddr];
  end

  assign hit    = rd_data.valid && (rd_data.key == key_q);
  assign at_end = (idx == mprf_pkg::IDX_W'(mprf_pkg::ROUTE_ENTRIES - 1));

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    free_idx_next  = free_idx;
    free_seen_next = free_seen;
    op_q_next      = op_q;
    key_q_next     = key_q;
    hop_q_next     = hop_q;
    we             = 1'b0;
    waddr          = idx;
    wdata          = '0;
    raddr          = idx;
    rsp            = '0;
    rsp.op         = op_q;

    unique case (state)
      T_CLEAR: begin
        // sweep the table once after reset, invalidating every entry
        we       = 1'b1;
        idx_next = idx + 1'b1;
        if (at_end) begin
          idx_next   = '0;
          state_next = T_IDLE;
        end
      end

      T_IDLE: begin
        rsp.ready = 1'b1;
        raddr     = '0;
        if (req.valid) begin
          op_q_next      = req.op;
          key_q_next     = req.key;
          hop_q_next     = req.hop;
          idx_next       = '0;
          free_seen_next = 1'b0;
          state_next     = T_SCAN;
        end
      end

      T_SCAN: begin
        // rd_data holds entry idx; prefetch idx + 1
        raddr    = at_end ? '0 : idx + 1'b1;
        idx_next = idx + 1'b1;
        if (!free_seen && !rd_data.valid) begin
          free_seen_next = 1'b1;
          free_idx_next  = idx;
        end
        if (hit) begin
          rsp.done   = 1'b1;
          rsp.status = mprf_pkg::ST_OK;
          state_next = T_IDLE;
          unique case (op_q)
            mprf_pkg::TBL_LOOKUP: begin
              rsp.found = 1'b1;
              rsp.hop   = rd_data.hop;
            end
            mprf_pkg::TBL_INSERT: begin
              we    = 1'b1;
              wdata = '{valid: 1'b1, key: key_q, hop: hop_q};
            end
            mprf_pkg::TBL_REMOVE: begin
              we    = 1'b1;
              wdata = '{valid: 1'b0, key: key_q, hop: rd_data.hop};
            end
            default: begin
              rsp.status = mprf_pkg::ST_OK;
            end
          endcase
        end else if (at_end) begin
          rsp.done   = 1'b1;
          rsp.status = mprf_pkg::ST_OK;
          state_next = T_IDLE;
          unique case (op_q)
            mprf_pkg::TBL_LOOKUP: begin
              rsp.found = 1'b0;
            end
            mprf_pkg::TBL_INSERT: begin
              // new key goes into the lowest free slot
              wdata = '{valid: 1'b1, key: key_q, hop: hop_q};
              if (free_seen) begin
                we    = 1'b1;
                waddr = free_idx;
              end else if (!rd_data.valid) begin
                we = 1'b1;
              end else begin
                rsp.status = mprf_pkg::ST_FULL;
              end
            end
            mprf_pkg::TBL_REMOVE: begin
              rsp.status = mprf_pkg::ST_NOT_FOUND;
            end
            default: begin
              rsp.status = mprf_pkg::ST_OK;
            end
          endcase
        end
      end

      default: begin
        idx_next   = '0;
        state_next = T_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_CLEAR;
      idx       <= '0;
      free_seen <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      free_seen <= free_seen_next;
    end
    free_idx <= free_idx_next;
    op_q     <= op_q_next;
    key_q    <= key_q_next;
    hop_q    <= hop_q_next;
  end

endmodule

// ----- hdl/mesh_packet_route_filter_top.sv -----
// ----------------------------------------------------------------------------
// mesh_packet_route_filter_top
// Byte-stream IPv4/UDP mesh classifier with an exact-match route table.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle while the route table is idle and the
// result register can take a result. A frame's last byte answers in the next
// cycle when the frame is not mesh; a mesh frame, and every route insert or
// remove, runs a linear scan of the route memory at one entry per cycle,
// and no beat is taken until the scan answers (an insert of a new key always
// scans the whole table; a hit stops the scan early). The single read port
// of the route memory sets the scan rate. After reset the table runs a
// clearing pass over all ROUTE_ENTRIES entries during which no beat is
// accepted; configuration writes are taken at any time.
`include "mesh_packet_route_filter_top_defines.svh"

module mesh_packet_route_filter_top (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [15:0]                      cfg_data,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] data_byte, [39:8] route_address, [71:40] route_next_hop
  input  logic [mprf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tlast,
  // [1:0] operation
  input  logic [1:0]                       s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] verdict, [2:1] packet_class, [34:3] next_hop, [36:35] op_status,
  // [100:37] total_count, [164:101] passed_count, [228:165] dropped_count,
  // [292:229] forwarded_count, [295:293] zero
  output logic [mprf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] result_kind
  output logic                             m_axis_tuser
);

  logic [15:0] primary_port, sync_port;

  logic [mprf_pkg::POS_W-1:0] byte_position, pos_next;
  logic [15:0] eth_type, eth_cap;
  logic [7:0]  protocol, proto_cap;
  logic [31:0] dest_addr, dest_cap;
  logic [15:0] udp_port, port_cap;
  logic        is_mesh;

  logic [63:0] total_cnt, passed_cnt, dropped_cnt, fwd_cnt;
  logic [63:0] total_next, passed_next, dropped_next, fwd_next;

  logic                             out_valid;
  logic [mprf_pkg::OUT_TDATA_W-1:0] out_data;
  logic                             out_kind;

  logic        in_fire;
  logic [7:0]  in_byte;
  logic [31:0] in_addr, in_hop;

  logic        frame_upd;
  logic        frame_clr;
  logic        imm_fill;
  logic        fill;
  logic        res_kind;
  logic        res_verdict;
  logic [1:0]  res_class;
  logic [31:0] res_hop;
  logic [1:0]  res_status;

  mprf_pkg::tbl_req_t tbl_req;
  mprf_pkg::tbl_rsp_t tbl_rsp;

  mprf_route_table u_table (
    .clk (clk),
    .rst (rst),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_port <= mprf_pkg::PRIMARY_PORT_RST;
      sync_port    <= mprf_pkg::SYNC_PORT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mprf_pkg::CFG_PRIMARY_PORT: primary_port <= cfg_data;
        mprf_pkg::CFG_SYNC_PORT:    sync_port    <= cfg_data;
        default: primary_port <= primary_port;
      endcase
    end
  end

  assign in_byte = s_axis_tdata[7:0];
  assign in_addr = s_axis_tdata[39:8];
  assign in_hop  = s_axis_tdata[71:40];

  // hold input while the table scans or a result cannot leave
  assign s_axis_tready = tbl_rsp.ready && (!out_valid || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // header capture for the current byte
  always_comb begin
    eth_cap   = eth_type;
    proto_cap = protocol;
    dest_cap  = dest_addr;
    port_cap  = udp_port;
    priority if (byte_position == 6'd12) begin
      eth_cap = {in_byte, eth_type[7:0]};
    end else if (byte_position == 6'd13) begin
      eth_cap = {eth_type[15:8], in_byte};
    end else if (byte_position == 6'd23) begin
      proto_cap = in_byte;
    end else if (byte_position >= 6'd30 && byte_position <= 6'd33) begin
      dest_cap = {dest_addr[23:0], in_byte};
    end else if (byte_position == 6'd36) begin
      port_cap = {in_byte, udp_port[7:0]};
    end else if (byte_position == 6'd37) begin
      port_cap = {udp_port[15:8], in_byte};
    end
    pos_next = (byte_position >= mprf_pkg::MIN_LEN) ? mprf_pkg::MIN_LEN
                                                     : byte_position + 1'b1;
  end

  assign is_mesh = (pos_next == mprf_pkg::MIN_LEN) && (eth_cap == mprf_pkg::ETH_IPV4) &&
                   (proto_cap == mprf_pkg::PROTO_UDP) &&
                   ((port_cap == primary_port) || (port_cap == sync_port));

  always_comb begin
    frame_upd    = 1'b0;
    frame_clr    = 1'b0;
    imm_fill     = 1'b0;
    tbl_req      = '0;
    total_next   = total_cnt;
    passed_next  = passed_cnt;
    dropped_next = dropped_cnt;
    fwd_next     = fwd_cnt;
    res_kind     = mprf_pkg::KIND_VERDICT;
    res_verdict  = mprf_pkg::VERDICT_PASS;
    res_class    = mprf_pkg::CLS_NOT_MESH;
    res_hop      = '0;
    res_status   = mprf_pkg::ST_OK;

    if (in_fire) begin
      unique case (s_axis_tuser)
        mprf_pkg::OP_FRAME: begin
          frame_upd = 1'b1;
          if (s_axis_tlast) begin
            frame_clr = 1'b1;
            if (is_mesh) begin
              tbl_req.valid = 1'b1;
              tbl_req.op    = mprf_pkg::TBL_LOOKUP;
              tbl_req.key   = dest_cap;
            end else begin
              imm_fill    = 1'b1;
              total_next  = total_cnt + 64'd1;
              passed_next = passed_cnt + 64'd1;
            end
          end
        end
        mprf_pkg::OP_INSERT: begin
          tbl_req.valid = 1'b1;
          tbl_req.op    = mprf_pkg::TBL_INSERT;
          tbl_req.key   = in_addr;
          tbl_req.hop   = in_hop;
        end
        mprf_pkg::OP_REMOVE: begin
          tbl_req.valid = 1'b1;
          tbl_req.op    = mprf_pkg::TBL_REMOVE;
          tbl_req.key   = in_addr;
        end
        default: begin
          frame_upd = 1'b0;
        end
      endcase
    end

    if (tbl_rsp.done) begin
      if (tbl_rsp.op == mprf_pkg::TBL_LOOKUP) begin
        total_next = total_cnt + 64'd1;
        if (tbl_rsp.found) begin
          fwd_next  = fwd_cnt + 64'd1;
          res_class = mprf_pkg::CLS_ROUTED;
          res_hop   = tbl_rsp.hop;
        end else begin
          dropped_next = dropped_cnt + 64'd1;
          res_class    = mprf_pkg::CLS_NO_ROUTE;
          res_verdict  = mprf_pkg::VERDICT_DROP;
        end
      end else begin
        res_kind   = mprf_pkg::KIND_ROUTE;
        res_status = tbl_rsp.status;
      end
    end
  end

  assign fill = imm_fill || tbl_rsp.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      eth_type      <= '0;
      protocol      <= '0;
      dest_addr     <= '0;
      udp_port      <= '0;
      total_cnt     <= '0;
      passed_cnt    <= '0;
      dropped_cnt   <= '0;
      fwd_cnt       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (frame_clr) begin
        byte_position <= '0;
        eth_type      <= '0;
        protocol      <= '0;
        dest_addr     <= '0;
        udp_port      <= '0;
      end else if (frame_upd) begin
        byte_position <= pos_next;
        eth_type      <= eth_cap;
        protocol      <= proto_cap;
        dest_addr     <= dest_cap;
        udp_port      <= port_cap;
      end
      total_cnt   <= total_next;
      passed_cnt  <= passed_next;
      dropped_cnt <= dropped_next;
      fwd_cnt     <= fwd_next;
      if (fill) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      out_kind <= res_kind;
      out_data <= {mprf_pkg::OUT_PAD_W'(1'b0), fwd_next, dropped_next, passed_next,
                   total_next, res_status, res_hop, res_class, res_verdict};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;

  `MPRF_ASSERT_SAME(a_req_only_idle, tbl_req.valid, tbl_rsp.ready, "table request while busy")
  `MPRF_ASSERT_NEXT(a_req_starts_scan, tbl_req.valid, !tbl_rsp.ready, "table scan not started")
  `MPRF_ASSERT_SAME(a_rsp_slot_free, tbl_rsp.done, !out_valid, "table result with output full")
  `MPRF_ASSERT_SAME(a_pos_saturates, 1'b1, byte_position <= mprf_pkg::MIN_LEN, "byte position overrun")

endmodule

// ----- verif/tb_mesh_packet_route_filter_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the mesh packet route filter
// Streams frame bytes and route table updates into the filter with random
// gaps and result back-pressure, predicts every verdict and table status in
// a shadow of the classifier, the route table and the frame counters, and
// compares each result beat field by field. Runs several UDP port settings
// and finishes with a phase that fills the route table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct packed {
  logic        kind;
  logic        verdict;
  logic [1:0]  cls;
  logic [31:0] hop;
  logic [1:0]  status;
  logic [63:0] total;
  logic [63:0] passed;
  logic [63:0] dropped;
  logic [63:0] forwarded;
} reply_t;

class mesh_filter_shadow;
  logic [15:0] port_cfg [2];
  logic [5:0]  pos;
  logic [15:0] ethertype;
  logic [7:0]  ip_proto;
  logic [31:0] dest_addr;
  logic [15:0] udp_dport;
  logic [31:0] route_key [mprf_pkg::ROUTE_ENTRIES];
  logic [31:0] route_hop [mprf_pkg::ROUTE_ENTRIES];
  bit          route_used [mprf_pkg::ROUTE_ENTRIES];
  logic [63:0] n_frames, n_plain, n_dropped, n_routed;
  reply_t      replies_due [$];
  int          fails, n_checked, n_table_ops;

  function new();
    port_cfg[0] = mprf_pkg::PRIMARY_PORT_RST;
    port_cfg[1] = mprf_pkg::SYNC_PORT_RST;
    clear_frame();
    foreach (route_used[i]) route_used[i] = 1'b0;
    n_frames = '0;
    n_plain = '0;
    n_dropped = '0;
    n_routed = '0;
    fails = 0;
    n_checked = 0;
    n_table_ops = 0;
  endfunction

  function void clear_frame();
    pos = '0;
    ethertype = '0;
    ip_proto = '0;
    dest_addr = '0;
    udp_dport = '0;
  endfunction

  function int find_slot(logic [31:0] key);
    for (int i = 0; i < mprf_pkg::ROUTE_ENTRIES; i++)
      if (route_used[i] && route_key[i] == key) return i;
    return -1;
  endfunction

  function bit table_full();
    foreach (route_used[i]) if (!route_used[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Predict the reply, if any, of one accepted input beat.
  function void apply_beat(logic [1:0] op, logic [7:0] b, logic last,
                           logic [31:0] addr, logic [31:0] hop_in);
    reply_t r;
    int     slot;
    bit     mesh;
    r = '0;
    case (op)
      mprf_pkg::OP_FRAME: begin
        case (pos)
          6'd12: ethertype[15:8] = b;
          6'd13: ethertype[7:0] = b;
          6'd23: ip_proto = b;
          6'd30, 6'd31, 6'd32, 6'd33: dest_addr = {dest_addr[23:0], b};
          6'd36: udp_dport[15:8] = b;
          6'd37: udp_dport[7:0] = b;
          default: ;
        endcase
        if (pos < mprf_pkg::MIN_LEN) pos = pos + 6'd1;
        if (!last) return;
        mesh = pos == mprf_pkg::MIN_LEN && ethertype == mprf_pkg::ETH_IPV4 &&
               ip_proto == mprf_pkg::PROTO_UDP &&
               (udp_dport == port_cfg[0] || udp_dport == port_cfg[1]);
        n_frames += 1;
        r.kind = mprf_pkg::KIND_VERDICT;
        r.status = mprf_pkg::ST_OK;
        if (!mesh) begin
          n_plain += 1;
          r.verdict = mprf_pkg::VERDICT_PASS;
          r.cls = mprf_pkg::CLS_NOT_MESH;
        end else begin
          slot = find_slot(dest_addr);
          if (slot >= 0) begin
            n_routed += 1;
            r.verdict = mprf_pkg::VERDICT_PASS;
            r.cls = mprf_pkg::CLS_ROUTED;
            r.hop = route_hop[slot];
          end else begin
            n_dropped += 1;
            r.verdict = mprf_pkg::VERDICT_DROP;
            r.cls = mprf_pkg::CLS_NO_ROUTE;
          end
        end
        clear_frame();
      end
      mprf_pkg::OP_INSERT: begin
        n_table_ops++;
        r.kind = mprf_pkg::KIND_ROUTE;
        r.status = mprf_pkg::ST_OK;
        slot = find_slot(addr);
        if (slot < 0)
          for (int i = 0; i < mprf_pkg::ROUTE_ENTRIES; i++)
            if (!route_used[i]) begin
              slot = i;
              break;
            end
        if (slot >= 0) begin
          route_key[slot] = addr;
          route_hop[slot] = hop_in;
          route_used[slot] = 1'b1;
        end else begin
          r.status = mprf_pkg::ST_FULL;
        end
      end
      mprf_pkg::OP_REMOVE: begin
        n_table_ops++;
        r.kind = mprf_pkg::KIND_ROUTE;
        slot = find_slot(addr);
        if (slot >= 0) begin
          route_used[slot] = 1'b0;
          r.status = mprf_pkg::ST_OK;
        end else begin
          r.status = mprf_pkg::ST_NOT_FOUND;
        end
      end
      default: return;
    endcase
    r.total = n_frames;
    r.passed = n_plain;
    r.dropped = n_dropped;
    r.forwarded = n_routed;
    replies_due.push_back(r);
  endfunction

  function int field_differs(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (fails < 10)
        $display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function void compare_reply(logic kind, logic [mprf_pkg::OUT_TDATA_W-1:0] d);
    reply_t want, got;
    int     bad;
    got.kind = kind;
    got.verdict = d[0];
    got.cls = d[2:1];
    got.hop = d[34:3];
    got.status = d[36:35];
    got.total = d[100:37];
    got.passed = d[164:101];
    got.dropped = d[228:165];
    got.forwarded = d[292:229];
    if (replies_due.size() == 0) begin
      if (fails < 10) $display("%0t result beat with no reply pending", $time);
      fails++;
      return;
    end
    want = replies_due.pop_front();
    bad = 0;
    bad += field_differs("result_kind", 64'(want.kind), 64'(got.kind));
    bad += field_differs("verdict", 64'(want.verdict), 64'(got.verdict));
    bad += field_differs("packet_class", 64'(want.cls), 64'(got.cls));
    bad += field_differs("next_hop", 64'(want.hop), 64'(got.hop));
    bad += field_differs("op_status", 64'(want.status), 64'(got.status));
    bad += field_differs("total_count", want.total, got.total);
    bad += field_differs("passed_count", want.passed, got.passed);
    bad += field_differs("dropped_count", want.dropped, got.dropped);
    bad += field_differs("forwarded_count", want.forwarded, got.forwarded);
    if (bad != 0) fails++;
    n_checked++;
  endfunction

  function void check_drained();
    if (replies_due.size() != 0) begin
      $display("%0d expected replies never arrived", replies_due.size());
      fails += replies_due.size();
    end
  endfunction
endclass

module tb_mesh_packet_route_filter_top;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [15:0] ETH_IPV6     = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam int          RANDOM_ITEMS = 540;
  localparam int          N_SETTINGS   = 6;
  localparam int          LIMIT_CYCLES = 12_000_000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic                             cfg_index = mprf_pkg::CFG_PRIMARY_PORT;
  logic [15:0]                      cfg_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [mprf_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tlast = 1'b0;
  logic [1:0]                       s_axis_tuser = mprf_pkg::OP_FRAME;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [mprf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;

  mesh_filter_shadow shadow = new();

  logic [31:0] key_pool [10];
  int          items_sent = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;

  mesh_packet_route_filter_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else begin
      m_axis_tready = 1'b1;
      stall_left = pick_gap(sink_calm);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      shadow.compare_reply(m_axis_tuser, m_axis_tdata);
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return key_pool[$urandom_range(0, 9)];
  endfunction

  task automatic send_beat(logic [1:0] op, logic [7:0] b, logic last,
                           logic [31:0] addr, logic [31:0] hop);
    int gap;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tlast = last;
    s_axis_tdata = {hop, addr, b};
    do @(posedge clk); while (!s_axis_tready);
    shadow.apply_beat(op, b, last, addr, hop);
    if (op != OP_UNUSED) items_sent++;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic route_beat(logic [1:0] op, logic [31:0] addr, logic [31:0] hop);
    send_beat(op, 8'($urandom), 1'($urandom_range(0, 1)), addr, hop);
  endtask

  task automatic random_route_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) route_beat(mprf_pkg::OP_INSERT, pick_key(), $urandom);
    else if (r < 93) route_beat(mprf_pkg::OP_REMOVE, pick_key(), $urandom);
    else route_beat(OP_UNUSED, $urandom, $urandom);
  endtask

  // shaped frames carry an IPv4/UDP header; spoil 1 breaks the ethertype,
  // spoil 2 the protocol
  task automatic send_frame(int len, bit shaped, logic [31:0] dst,
                            logic [15:0] dport, int spoil);
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [7:0]  b;
    etype = (spoil == 1) ? ETH_IPV6 : mprf_pkg::ETH_IPV4;
    proto = (spoil == 2) ? PROTO_TCP : mprf_pkg::PROTO_UDP;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (shaped)
        case (i)
          12: b = etype[15:8];
          13: b = etype[7:0];
          23: b = proto;
          30: b = dst[31:24];
          31: b = dst[23:16];
          32: b = dst[15:8];
          33: b = dst[7:0];
          36: b = dport[15:8];
          37: b = dport[7:0];
          default: ;
        endcase
      send_beat(mprf_pkg::OP_FRAME, b, i == len - 1, $urandom, $urandom);
      // table updates may slip in between bytes
      if (i != len - 1 && $urandom_range(0, 99) < 2) random_route_op();
    end
  endtask

  task automatic random_transaction();
    int          r, s, len, spoil;
    logic [15:0] dport;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      s = $urandom_range(0, 9);
      len = (s < 2) ? 42 : (s < 3) ? 41 : (s < 8) ? $urandom_range(43, 48)
                                                 : $urandom_range(49, 90);
      s = $urandom_range(0, 19);
      dport = (s < 9) ? shadow.port_cfg[0] : (s < 18) ? shadow.port_cfg[1]
                                                      : 16'($urandom);
      spoil = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
      send_frame(len, 1'b1, pick_key(), dport, spoil);
    end else if (r < 70) begin
      send_frame($urandom_range(1, 70), 1'b0, '0, '0, 0);
    end else begin
      random_route_op();
    end
  endtask

  // hold until every reply is back, then let a full table scan pass
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (mprf_pkg::ROUTE_ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_port(logic idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    shadow.port_cfg[idx] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int          phase_end;
    logic [15:0] shared_port;
    logic [31:0] far_key;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 10; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // table basics on an empty table, then frame bytes around table updates
    route_beat(mprf_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    route_beat(mprf_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    route_beat(mprf_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    route_beat(mprf_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678);
    route_beat(mprf_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    route_beat(mprf_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(OP_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(mprf_pkg::OP_FRAME, 8'hFF, 1'b1, 32'h0000_0000, 32'h0000_0000);
    send_beat(mprf_pkg::OP_FRAME, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    route_beat(mprf_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_beat(OP_UNUSED, 8'h00, 1'b0, 32'h0000_0000, 32'h0000_0000);
    send_beat(mprf_pkg::OP_FRAME, 8'h00, 1'b1, 32'h0000_0000, 32'h0000_0000);

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      if (ph != 0) begin
        settle();
        case (ph)
          1: begin
            write_port(mprf_pkg::CFG_PRIMARY_PORT, 16'h0000);
            write_port(mprf_pkg::CFG_SYNC_PORT, 16'hFFFF);
          end
          2: begin
            write_port(mprf_pkg::CFG_PRIMARY_PORT, 16'hFFFF);
            write_port(mprf_pkg::CFG_SYNC_PORT, 16'h0000);
          end
          3: begin
            shared_port = 16'($urandom);
            write_port(mprf_pkg::CFG_PRIMARY_PORT, shared_port);
            write_port(mprf_pkg::CFG_SYNC_PORT, shared_port);
          end
          4: begin
            write_port(mprf_pkg::CFG_PRIMARY_PORT, 16'($urandom));
            write_port(mprf_pkg::CFG_SYNC_PORT, 16'($urandom));
          end
          default: begin
            write_port(mprf_pkg::CFG_PRIMARY_PORT, mprf_pkg::PRIMARY_PORT_RST);
            write_port(mprf_pkg::CFG_SYNC_PORT, mprf_pkg::SYNC_PORT_RST);
          end
        endcase
      end
      src_calm = (ph == 3);
      sink_calm = (ph == 3);
      phase_end = items_sent + RANDOM_ITEMS / N_SETTINGS;
      while (items_sent < phase_end) random_transaction();
    end

    // fill the table, then work at the edge of full
    settle();
    src_calm = 1'b1;
    sink_calm = 1'b0;
    while (!shadow.table_full()) route_beat(mprf_pkg::OP_INSERT, $urandom, $urandom);
    route_beat(mprf_pkg::OP_INSERT, $urandom, $urandom);
    far_key = shadow.route_key[mprf_pkg::ROUTE_ENTRIES-1];
    route_beat(mprf_pkg::OP_INSERT, far_key, $urandom);
    src_calm = 1'b0;
    send_frame(42, 1'b1, far_key, shadow.port_cfg[0], 0);
    send_frame(44, 1'b1, $urandom, shadow.port_cfg[1], 0);
    route_beat(mprf_pkg::OP_REMOVE, shadow.route_key[mprf_pkg::ROUTE_ENTRIES/2], $urandom);
    route_beat(mprf_pkg::OP_INSERT, $urandom, $urandom);
    route_beat(mprf_pkg::OP_INSERT, $urandom, $urandom);
    route_beat(mprf_pkg::OP_REMOVE, $urandom, $urandom);

    settle();
    shadow.check_drained();
    $display("Covered %0d frames: %0d plain, %0d forwarded, %0d dropped for no route",
             shadow.n_frames, shadow.n_plain, shadow.n_routed, shadow.n_dropped);
    $display("%0d table updates over %0d port settings and a full table; %0d replies, %0d bad",
             shadow.n_table_ops, N_SETTINGS, shadow.n_checked, shadow.fails);
    if (shadow.fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
